### src/trcm_pkg.sv
// ----------------------------------------------------------------------------
// trcm_pkg
// Types, instruction codes and constants of the two-register rotate machine.
// ----------------------------------------------------------------------------
`default_nettype none

package trcm_pkg;

  localparam int DATA_WORDS_DEF = 4096;

  localparam logic [3:0] KIND_NOP    = 4'd0;
  localparam logic [3:0] KIND_FLIP   = 4'd1;
  localparam logic [3:0] KIND_ROTATE = 4'd2;
  localparam logic [3:0] KIND_SWAP   = 4'd3;
  localparam logic [3:0] KIND_LDC    = 4'd4;
  localparam logic [3:0] KIND_LOAD   = 4'd5;
  localparam logic [3:0] KIND_STORE  = 4'd6;
  localparam logic [3:0] KIND_JUMPIF = 4'd7;

  localparam logic [1:0] FAULT_NONE       = 2'd0;
  localparam logic [1:0] FAULT_LOAD_ADDR  = 2'd1;
  localparam logic [1:0] FAULT_STORE_ADDR = 2'd2;
  localparam logic [1:0] FAULT_UNRESOLVED = 2'd3;

  localparam logic [63:0] CHAR_PORT   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WORD_PORT   = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] ASCII_LIMIT = 64'h80;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] immediate;
    logic [7:0]  in_char;
  } in_item_t;

  typedef struct packed {
    logic [63:0] next_ip;
    logic [63:0] reg_a;
    logic [63:0] reg_b;
    logic        char_taken;
    logic [6:0]  out_char;
    logic        out_char_valid;
    logic        out_word_valid;
    logic [1:0]  fault;
  } out_item_t;

endpackage

`default_nettype wire

### src/two_register_rotate_machine_core_top.sv
// ----------------------------------------------------------------------------
// two_register_rotate_machine_core_top
// Two-register 64-bit rotate machine, one instruction per transaction.
//
// Input channel in_valid/in_stall/in_data carries one instruction (kind,
// immediate, next input byte). Output channel out_valid/out_stall/out_data
// returns one result per instruction: next instruction pointer, A, B, port
// effects and fault code.
// The result is registered: the input register takes the instruction, then
// execute writes the result register. Throughput: one instruction per cycle
// while out_stall does not hold a result; registers A, B and IP update in the
// execute cycle. The data store read is issued ahead at the next value of A,
// so loads keep the one-per-cycle rate.
// Reset: A, B and IP clear to zero, then a clearing pass writes zero to all
// DATA_WORDS words, one per cycle; in_stall stays high throughout the pass.
// While out_stall holds a result, one more instruction waits in the input
// register and then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module two_register_rotate_machine_core_top #(
  parameter int DATA_WORDS = trcm_pkg::DATA_WORDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire trcm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output trcm_pkg::out_item_t      out_data
);

  localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  logic                in_valid_r;
  trcm_pkg::in_item_t  in_item_r;
  logic [63:0]         a_r;
  logic [63:0]         b_r;
  logic [63:0]         ip_r;
  logic                out_valid_r;
  trcm_pkg::out_item_t out_item_r;
  logic                clearing_r;
  logic [AW-1:0]       clr_addr_r;

  trcm_pkg::out_item_t res;
  logic                store_en;
  logic                exec_fire;
  logic                in_take;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [63:0]         wr_data;
  logic [AW-1:0]       rd_addr;
  logic [63:0]         load_data;

  assign exec_fire = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clearing_r || (in_valid_r && !exec_fire);
  assign in_take   = in_valid && !in_stall;

  assign wr_en   = clearing_r || (exec_fire && store_en);
  assign wr_addr = clearing_r ? clr_addr_r : b_r[AW-1:0];
  assign wr_data = clearing_r ? 64'd0 : a_r;
  assign rd_addr = exec_fire ? res.reg_a[AW-1:0] : a_r[AW-1:0];

  trcm_exec #(
    .DATA_WORDS(DATA_WORDS)
  ) u_exec (
    .item     (in_item_r),
    .a        (a_r),
    .b        (b_r),
    .ip       (ip_r),
    .load_data(load_data),
    .res      (res),
    .store_en (store_en)
  );

  trcm_ram #(
    .DATA_WORDS(DATA_WORDS),
    .AW        (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(load_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == AW'(DATA_WORDS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      ip_r        <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (exec_fire) begin
        in_valid_r <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
        a_r         <= res.reg_a;
        b_r         <= res.reg_b;
        ip_r        <= res.next_ip;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (exec_fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

### src/trcm_ram.sv
// ----------------------------------------------------------------------------
// trcm_ram
// Data store: one write port, one registered read port, write-first.
// ----------------------------------------------------------------------------
`default_nettype none

module trcm_ram #(
  parameter int DATA_WORDS = trcm_pkg::DATA_WORDS_DEF,
  parameter int AW         = $clog2(DATA_WORDS)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [63:0]   wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [63:0]   rd_data
);

  logic [63:0] mem [DATA_WORDS];
  logic [63:0] mem_rd_r;
  logic [63:0] byp_data_r;
  logic        byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r   <= mem[rd_addr];
    byp_r      <= wr_en && (wr_addr == rd_addr);
    byp_data_r <= wr_data;
  end

  assign rd_data = byp_r ? byp_data_r : mem_rd_r;

endmodule

`default_nettype wire

### src/trcm_exec.sv
// ----------------------------------------------------------------------------
// trcm_exec
// Single-pass instruction execute: next registers, port effects and faults.
// ----------------------------------------------------------------------------
`default_nettype none

module trcm_exec #(
  parameter int DATA_WORDS = trcm_pkg::DATA_WORDS_DEF
) (
  input  wire trcm_pkg::in_item_t  item,
  input  wire logic [63:0]         a,
  input  wire logic [63:0]         b,
  input  wire logic [63:0]         ip,
  input  wire logic [63:0]         load_data,
  output trcm_pkg::out_item_t      res,
  output logic                     store_en
);

  logic [127:0] rot_dbl;
  logic [63:0]  ip_inc;
  logic         a_in_range;
  logic         b_in_range;

  assign rot_dbl    = {a, a} >> item.immediate[5:0];
  assign ip_inc     = ip + 64'd1;
  assign a_in_range = a < 64'(DATA_WORDS);
  assign b_in_range = b < 64'(DATA_WORDS);

  always_comb begin
    res                = '0;
    res.next_ip        = ip_inc;
    res.reg_a          = a;
    res.reg_b          = b;
    res.fault          = trcm_pkg::FAULT_NONE;
    store_en           = 1'b0;
    case (item.kind)
      trcm_pkg::KIND_NOP: begin
      end
      trcm_pkg::KIND_FLIP: begin
        res.reg_a = a ^ 64'd1;
      end
      trcm_pkg::KIND_ROTATE: begin
        res.reg_a = rot_dbl[63:0];
      end
      trcm_pkg::KIND_SWAP: begin
        res.reg_a = b;
        res.reg_b = a;
      end
      trcm_pkg::KIND_LDC: begin
        res.reg_a = item.immediate;
      end
      trcm_pkg::KIND_LOAD: begin
        if (a == trcm_pkg::CHAR_PORT) begin
          res.char_taken = 1'b1;
          res.reg_a      = item.in_char[7] ? 64'd0 : {56'd0, item.in_char};
        end else if (a == trcm_pkg::WORD_PORT) begin
          res.reg_a = 64'd0;
        end else if (a_in_range) begin
          res.reg_a = load_data;
        end else begin
          res.reg_a   = 64'd0;
          res.fault   = trcm_pkg::FAULT_LOAD_ADDR;
          res.next_ip = ip;
        end
      end
      trcm_pkg::KIND_STORE: begin
        if (b == trcm_pkg::CHAR_PORT) begin
          if (a < trcm_pkg::ASCII_LIMIT) begin
            res.out_char       = a[6:0];
            res.out_char_valid = 1'b1;
          end
        end else if (b == trcm_pkg::WORD_PORT) begin
          res.out_word_valid = 1'b1;
        end else if (b_in_range) begin
          store_en = 1'b1;
        end else begin
          res.fault   = trcm_pkg::FAULT_STORE_ADDR;
          res.next_ip = ip;
        end
      end
      trcm_pkg::KIND_JUMPIF: begin
        if (a[0]) begin
          res.next_ip = b;
          res.reg_b   = ip_inc;
        end
      end
      default: begin
        res.fault   = trcm_pkg::FAULT_UNRESOLVED;
        res.next_ip = ip;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/trcm_checker.sv
// ----------------------------------------------------------------------------
// trcm_checker
// Port-level checks of the rotate machine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trcm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire trcm_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire trcm_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_fault_no_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fault != trcm_pkg::FAULT_NONE) |->
      !out_data.char_taken && !out_data.out_char_valid && !out_data.out_word_valid)
    else $error("faulted instruction touched a port");

  a_load_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fault == trcm_pkg::FAULT_LOAD_ADDR) |->
      out_data.reg_a == 64'd0)
    else $error("bad load left A nonzero");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted during the store clearing pass");

endmodule

bind two_register_rotate_machine_core_top trcm_checker u_trcm_checker (.*);

`default_nettype wire
